### hdl/mbwrp_pkg.sv
package mbwrp_pkg;

    // Frame layout of the fixed-length read response
    localparam int unsigned FRAME_BYTES = 23;
    localparam int unsigned DATA_BYTES  = 18;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned DATA_IDX_W  = 5;

    localparam logic [COUNT_W-1:0] POS_FUNC     = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] POS_THIRD    = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] POS_DATA_LO  = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] POS_DATA_HI  = COUNT_W'(3 + DATA_BYTES - 1);
    localparam logic [COUNT_W-1:0] POS_CRC_LO   = COUNT_W'(FRAME_BYTES - 2);
    localparam logic [COUNT_W-1:0] POS_CRC_HI   = COUNT_W'(FRAME_BYTES - 1);
    localparam logic [COUNT_W-1:0] FRAME_COUNT  = COUNT_W'(FRAME_BYTES);

    // CRC-16/Modbus
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Exception flag in the function byte
    localparam logic [7:0] FUNC_EXC_MASK = 8'h80;

    // Item modes
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_CLEAR   = 2'd1;
    localparam logic [1:0] MODE_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        RES_OK          = 2'd0,
        RES_NO_RESPONSE = 2'd1,
        RES_CRC_ERROR   = 2'd2,
        RES_EXCEPTION   = 2'd3
    } result_t;

    // One byte of CRC-16/Modbus, bit loop unrolled
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### hdl/modbus_weight_response_parser_unit.sv
// Channel | valid    | stall     | payload
// --------+----------+-----------+-------------------------------------------------
// input   | in_valid | in_stall  | mode, rx_byte
// output  | out_valid| out_stall | result_code, exception_code, adc_raw, empty_load,
//         |          |           | scale_bits, weight_grams, status_word, bytes_received
//
// One item per cycle while no result is stalled; a taken item passes through the input
// register, then the result register (the CRC byte step sits between them).
// Reset clears the byte count, flags and header bytes, and loads the CRC with FFFF.
// A stalled result holds the result register; the item in the input register
// then waits and in_stall rises, so at most one item queues behind a result.
module modbus_weight_response_parser_unit
    import mbwrp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          mode,
    input  logic [7:0]          rx_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          result_code,
    output logic [7:0]          exception_code,
    output logic signed [31:0]  adc_raw,
    output logic signed [31:0]  empty_load,
    output logic [31:0]         scale_bits,
    output logic signed [31:0]  weight_grams,
    output logic [15:0]         status_word,
    output logic [4:0]          bytes_received
);

    // Input register
    logic                   s1_valid_reg;
    logic [1:0]             s1_mode_reg;
    logic [7:0]             s1_byte_reg;

    // Frame state
    logic [COUNT_W-1:0]     byte_count_reg, byte_count_next;
    logic [15:0]            crc_accum_reg, crc_accum_next;
    logic [7:0]             function_byte_reg, function_byte_next;
    logic [7:0]             third_byte_reg, third_byte_next;
    logic [7:0]             crc_low_byte_reg, crc_low_byte_next;
    logic                   frame_done_reg, frame_done_next;
    logic [7:0]             data_store_reg [DATA_BYTES];

    // Result register
    logic                   out_valid_reg;
    result_t                result_code_reg, result_code_next;
    logic [7:0]             exception_code_reg, exception_code_next;
    logic [31:0]            adc_raw_reg, adc_raw_next;
    logic [31:0]            empty_load_reg, empty_load_next;
    logic [31:0]            scale_bits_reg, scale_bits_next;
    logic [31:0]            weight_grams_reg, weight_grams_next;
    logic [15:0]            status_word_reg, status_word_next;
    logic [COUNT_W-1:0]     bytes_received_reg, bytes_received_next;

    logic                   out_free;
    logic                   proc_fire;
    logic                   in_accept;
    logic                   res_valid;
    logic                   store_we;
    logic [DATA_IDX_W-1:0]  store_idx;
    logic [15:0]            crc_rx;

    // Handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (proc_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= rx_byte;
        end
    end

    assign store_idx = DATA_IDX_W'(byte_count_reg - POS_DATA_LO);
    assign crc_rx    = {s1_byte_reg, crc_low_byte_reg};

    // Frame update and result decode
    always_comb
    begin
        byte_count_next     = byte_count_reg;
        crc_accum_next      = crc_accum_reg;
        function_byte_next  = function_byte_reg;
        third_byte_next     = third_byte_reg;
        crc_low_byte_next   = crc_low_byte_reg;
        frame_done_next     = frame_done_reg;
        store_we            = 1'b0;
        res_valid           = 1'b0;
        result_code_next    = RES_OK;
        exception_code_next = 8'h00;
        adc_raw_next        = 32'h0;
        empty_load_next     = 32'h0;
        scale_bits_next     = 32'h0;
        weight_grams_next   = 32'h0;
        status_word_next    = 16'h0;
        bytes_received_next = byte_count_reg;

        case (s1_mode_reg)
            MODE_CLEAR:
            begin
                byte_count_next    = '0;
                crc_accum_next     = CRC_INIT;
                function_byte_next = 8'h00;
                third_byte_next    = 8'h00;
                crc_low_byte_next  = 8'h00;
                frame_done_next    = 1'b0;
            end
            MODE_TIMEOUT:
            begin
                if (byte_count_reg < FRAME_COUNT)
                begin
                    res_valid        = 1'b1;
                    result_code_next = RES_NO_RESPONSE;
                end
            end
            MODE_BYTE:
            begin
                if (!frame_done_reg && byte_count_reg < FRAME_COUNT)
                begin
                    byte_count_next = byte_count_reg + COUNT_W'(1);
                    if (byte_count_reg < POS_CRC_LO)
                    begin
                        crc_accum_next = crc16_byte(crc_accum_reg, s1_byte_reg);
                    end
                    if (byte_count_reg == POS_FUNC)
                    begin
                        function_byte_next = s1_byte_reg;
                    end
                    else if (byte_count_reg == POS_THIRD)
                    begin
                        third_byte_next = s1_byte_reg;
                    end
                    else if (byte_count_reg inside {[POS_DATA_LO:POS_DATA_HI]})
                    begin
                        store_we = 1'b1;
                    end
                    else if (byte_count_reg == POS_CRC_LO)
                    begin
                        crc_low_byte_next = s1_byte_reg;
                    end

                    // Last byte closes the frame
                    if (byte_count_reg == POS_CRC_HI)
                    begin
                        frame_done_next     = 1'b1;
                        res_valid           = 1'b1;
                        bytes_received_next = FRAME_COUNT;
                        if (crc_rx != crc_accum_reg)
                        begin
                            result_code_next = RES_CRC_ERROR;
                        end
                        else if ((function_byte_reg & FUNC_EXC_MASK) != 8'h00)
                        begin
                            result_code_next    = RES_EXCEPTION;
                            exception_code_next = third_byte_reg;
                        end
                        else
                        begin
                            result_code_next  = RES_OK;
                            adc_raw_next      = {data_store_reg[3], data_store_reg[2],
                                                 data_store_reg[1], data_store_reg[0]};
                            empty_load_next   = {data_store_reg[7], data_store_reg[6],
                                                 data_store_reg[5], data_store_reg[4]};
                            scale_bits_next   = {data_store_reg[11], data_store_reg[10],
                                                 data_store_reg[9], data_store_reg[8]};
                            weight_grams_next = {data_store_reg[15], data_store_reg[14],
                                                 data_store_reg[13], data_store_reg[12]};
                            status_word_next  = {data_store_reg[16], data_store_reg[17]};
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            crc_accum_reg     <= CRC_INIT;
            function_byte_reg <= 8'h00;
            third_byte_reg    <= 8'h00;
            crc_low_byte_reg  <= 8'h00;
            frame_done_reg    <= 1'b0;
        end
        else if (proc_fire)
        begin
            byte_count_reg    <= byte_count_next;
            crc_accum_reg     <= crc_accum_next;
            function_byte_reg <= function_byte_next;
            third_byte_reg    <= third_byte_next;
            crc_low_byte_reg  <= crc_low_byte_next;
            frame_done_reg    <= frame_done_next;
        end
    end

    // Data bytes of the frame
    always_ff @(posedge clk)
    begin
        if (proc_fire && store_we)
        begin
            data_store_reg[store_idx] <= s1_byte_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (proc_fire && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && res_valid)
        begin
            result_code_reg    <= result_code_next;
            exception_code_reg <= exception_code_next;
            adc_raw_reg        <= adc_raw_next;
            empty_load_reg     <= empty_load_next;
            scale_bits_reg     <= scale_bits_next;
            weight_grams_reg   <= weight_grams_next;
            status_word_reg    <= status_word_next;
            bytes_received_reg <= bytes_received_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_code    = result_code_reg;
    assign exception_code = exception_code_reg;
    assign adc_raw        = adc_raw_reg;
    assign empty_load     = empty_load_reg;
    assign scale_bits     = scale_bits_reg;
    assign weight_grams   = weight_grams_reg;
    assign status_word    = status_word_reg;
    assign bytes_received = bytes_received_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= FRAME_COUNT)
        else $error("byte count past frame length");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with nothing blocking");

    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_code == RES_NO_RESPONSE) |-> (bytes_received < FRAME_COUNT))
        else $error("short-response result with full count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_code != RES_NO_RESPONSE) |-> (bytes_received == FRAME_COUNT))
        else $error("frame result without full count");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_code != RES_OK) |->
            (adc_raw == 32'sd0 && weight_grams == 32'sd0 && status_word == 16'h0))
        else $error("data fields set on failed frame");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb
    import mbwrp_pkg::*;
();

    // Mode 3 carries no meaning and must be ignored by the parser
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Data fill patterns for generated frames
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        result_t            code;
        logic [7:0]         exc;
        logic signed [31:0] adc;
        logic signed [31:0] empty_ld;
        logic [31:0]        scale;
        logic signed [31:0] weight;
        logic [15:0]        status;
        logic [4:0]         count;
    } frame_result_t;

    // Predicts parser results from accepted items and checks what comes out
    class weight_frame_scoreboard;
        frame_result_t expected_results[$];
        logic [4:0]    byte_pos;
        logic [15:0]   crc_run;
        logic [7:0]    func_byte;
        logic [7:0]    code_byte;
        logic [7:0]    crc_lo;
        logic [7:0]    payload [DATA_BYTES];
        bit            complete;
        int            errors;
        int            checked;
        int            produced;
        int            code_seen [4];

        function new();
            clear_frame();
            errors = 0;
            checked = 0;
            produced = 0;
            foreach (code_seen[i])
                code_seen[i] = 0;
        endfunction

        function void clear_frame();
            byte_pos = '0;
            crc_run = CRC_INIT;
            func_byte = '0;
            code_byte = '0;
            crc_lo = '0;
            foreach (payload[i])
                payload[i] = '0;
            complete = 1'b0;
        endfunction

        // CRC-16/Modbus, one byte, LSB first
        static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            return c;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void push_result(frame_result_t r);
            expected_results.push_back(r);
            produced++;
        endfunction

        function void note_item(logic [1:0] m, logic [7:0] b);
            frame_result_t r;
            logic [4:0]    pos;
            logic [15:0]   rx_crc;
            r = '0;
            case (m)
                MODE_CLEAR:
                begin
                    clear_frame();
                end
                MODE_TIMEOUT:
                begin
                    // short or missing response only while the frame is open
                    if (byte_pos < FRAME_COUNT)
                    begin
                        r.code = RES_NO_RESPONSE;
                        r.count = byte_pos;
                        push_result(r);
                    end
                end
                MODE_BYTE:
                begin
                    if (!complete && byte_pos < FRAME_COUNT)
                    begin
                        pos = byte_pos;
                        byte_pos = byte_pos + 5'd1;
                        if (pos < POS_CRC_LO)
                            crc_run = crc_step(crc_run, b);
                        if (pos == POS_FUNC)
                            func_byte = b;
                        else if (pos == POS_THIRD)
                            code_byte = b;
                        else if (pos >= POS_DATA_LO && pos <= POS_DATA_HI)
                            payload[pos - POS_DATA_LO] = b;
                        else if (pos == POS_CRC_LO)
                            crc_lo = b;
                        // last byte closes the frame
                        if (pos == POS_CRC_HI)
                        begin
                            complete = 1'b1;
                            r.count = FRAME_COUNT;
                            rx_crc = {b, crc_lo};
                            if (rx_crc != crc_run)
                            begin
                                r.code = RES_CRC_ERROR;
                            end
                            else if ((func_byte & FUNC_EXC_MASK) != 8'h00)
                            begin
                                r.code = RES_EXCEPTION;
                                r.exc = code_byte;
                            end
                            else
                            begin
                                r.code = RES_OK;
                                r.adc = {payload[3], payload[2], payload[1], payload[0]};
                                r.empty_ld = {payload[7], payload[6], payload[5], payload[4]};
                                r.scale = {payload[11], payload[10], payload[9], payload[8]};
                                r.weight = {payload[15], payload[14], payload[13], payload[12]};
                                r.status = {payload[16], payload[17]};
                            end
                            push_result(r);
                        end
                    end
                end
                default:
                begin
                    // unused mode, no effect
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            end
        endfunction

        function void check_result(frame_result_t act);
            frame_result_t exp;
            if (expected_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual code %0d count %0d",
                         $time, act.code, act.count);
            end
            else
            begin
                exp = expected_results.pop_front();
                checked++;
                code_seen[exp.code]++;
                compare_field("result_code", 32'(exp.code), 32'(act.code));
                compare_field("exception_code", 32'(exp.exc), 32'(act.exc));
                compare_field("adc_raw", exp.adc, act.adc);
                compare_field("empty_load", exp.empty_ld, act.empty_ld);
                compare_field("scale_bits", exp.scale, act.scale);
                compare_field("weight_grams", exp.weight, act.weight);
                compare_field("status_word", 32'(exp.status), 32'(act.status));
                compare_field("bytes_received", 32'(exp.count), 32'(act.count));
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         mode;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         result_code;
    logic [7:0]         exception_code;
    logic signed [31:0] adc_raw;
    logic signed [31:0] empty_load;
    logic [31:0]        scale_bits;
    logic signed [31:0] weight_grams;
    logic [15:0]        status_word;
    logic [4:0]         bytes_received;

    weight_frame_scoreboard sb = new();

    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_request;
    int            hold_left;
    int            items_sent;
    logic [7:0]    frame_buf [0:22];
    frame_result_t seen_result;

    modbus_weight_response_parser_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_code    (result_code),
        .exception_code (exception_code),
        .adc_raw        (adc_raw),
        .empty_load     (empty_load),
        .scale_bits     (scale_bits),
        .weight_grams   (weight_grams),
        .status_word    (status_word),
        .bytes_received (bytes_received)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall, or a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                seen_result.code = result_t'(result_code);
                seen_result.exc = exception_code;
                seen_result.adc = adc_raw;
                seen_result.empty_ld = empty_load;
                seen_result.scale = scale_bits;
                seen_result.weight = weight_grams;
                seen_result.status = status_word;
                seen_result.count = bytes_received;
                sb.check_result(seen_result);
            end
        end
    end

    // Offer one item, with a random gap before it, and wait until it is taken
    task automatic send_item(input logic [1:0] m, input logic [7:0] b);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_item(m, b);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    // Stop offering until every expected result has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Fill frame_buf with a response and its CRC, optionally corrupted
    task automatic build_frame(input logic [7:0] func, input logic [7:0] third,
                               input int fill, input bit bad_crc);
        logic [15:0] crc;
        int          at;
        frame_buf[0] = 8'($urandom);
        frame_buf[1] = func;
        frame_buf[2] = third;
        for (int i = 3; i <= 20; i++)
        begin
            case (fill)
                FILL_ZEROS: frame_buf[i] = 8'h00;
                FILL_ONES:  frame_buf[i] = 8'hFF;
                default:    frame_buf[i] = 8'($urandom);
            endcase
        end
        crc = CRC_INIT;
        for (int i = 0; i <= 20; i++)
            crc = weight_frame_scoreboard::crc_step(crc, frame_buf[i]);
        frame_buf[21] = crc[7:0];
        frame_buf[22] = crc[15:8];
        if (bad_crc)
        begin
            at = 21 + $urandom_range(0, 1);
            frame_buf[at] = frame_buf[at] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    task automatic send_bytes(input int first, input int last);
        for (int i = first; i <= last; i++)
            send_item(MODE_BYTE, frame_buf[i]);
    endtask

    // Stimulus
    initial
    begin
        int         fr;
        int         r;
        int         n;
        logic [7:0] func;
        in_valid = 1'b0;
        mode = MODE_BYTE;
        rx_byte = 8'h00;
        rst_n = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        send_idle_pct = 7;
        recv_idle_pct = 50;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty timeout, unused mode, clear, all-ones frame, extra byte,
        // timeout after completion
        send_item(MODE_TIMEOUT, 8'h00);
        send_item(MODE_UNUSED, 8'hFF);
        send_item(MODE_CLEAR, 8'hA5);
        build_frame(8'h03, 8'h24, FILL_ONES, 1'b0);
        send_bytes(0, 22);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_TIMEOUT, 8'h5A);

        // Random frames, mostly well formed
        fr = 0;
        while (items_sent < 520 || sb.produced < 40)
        begin
            if (items_sent < 180)
            begin
                send_idle_pct = 7;
                recv_idle_pct = 50;
            end
            else if (items_sent < 360)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 7;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // long receiver hold-off while timeouts pile up, then drain
            if (fr == 12)
            begin
                hold_request = 1'b1;
                send_item(MODE_CLEAR, 8'($urandom));
                repeat (8) send_item(MODE_TIMEOUT, 8'($urandom));
                wait_drained();
            end

            send_item(MODE_CLEAR, 8'($urandom));
            r = $urandom_range(0, 99);
            func = ($urandom_range(0, 3) == 0) ? (8'($urandom) | 8'h80)
                                               : (8'($urandom) & 8'h7F);
            if (fr == 0)
                build_frame(8'h03, 8'($urandom), FILL_ZEROS, 1'b0);
            else if (fr == 1)
                build_frame(8'h83, 8'h02, FILL_RANDOM, 1'b0);
            else if (fr == 2)
                build_frame(8'h03, 8'($urandom), FILL_RANDOM, 1'b1);
            else
                build_frame(func, 8'($urandom), FILL_RANDOM, $urandom_range(0, 99) < 15);

            if (fr < 3 || r < 55)
            begin
                send_bytes(0, 22);
            end
            else if (r < 75)
            begin
                // short response, then possibly the rest of the same frame
                n = $urandom_range(0, 22);
                send_bytes(0, n - 1);
                send_item(MODE_TIMEOUT, 8'($urandom));
                if ($urandom_range(0, 1) == 1)
                    send_bytes(n, 22);
            end
            else if (r < 88)
            begin
                // noise
                repeat ($urandom_range(5, 15))
                    send_item(2'($urandom), 8'($urandom));
            end
            else
            begin
                send_bytes(0, 22);
                repeat ($urandom_range(1, 3))
                    send_item(MODE_BYTE, 8'($urandom));
                send_item(MODE_TIMEOUT, 8'($urandom));
            end
            fr++;
        end

        // Drain and let the pipeline settle
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Run covered %0d items in %0d frames, %0d results checked", items_sent, fr,
                 sb.checked);
        $display("Results: %0d ok, %0d short, %0d CRC errors, %0d exceptions",
                 sb.code_seen[RES_OK], sb.code_seen[RES_NO_RESPONSE],
                 sb.code_seen[RES_CRC_ERROR], sb.code_seen[RES_EXCEPTION]);
        if (sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/mbwrp_pkg.sv
hdl/modbus_weight_response_parser_unit.sv
sim/tb.sv
